@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file beg_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, clocked, disabled while reset is high
`define BEG_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// concurrent assertion, clocked, also checked around reset
`define BEG_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ hw/rtl/beg_pkg.sv @@
// ----------------------------------------------------------------------------
// beg_pkg
// Shared types and constants of the breakpoint envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package beg_pkg;

   // breakpoint table size and derived widths
   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int SEG_W      = CNT_W + 1;

   // shared multiply / divide unit
   localparam int MUL_STEPS  = 32;
   localparam int DIV_STEPS  = 64;
   localparam int MD_CNT_W   = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_CUE,
      OP_INSERT,
      OP_DELETE,
      OP_RESTART
   } op_type;

   typedef enum logic [2:0] {
      STS_OK,
      STS_FULL,
      STS_DUP,
      STS_LAST,
      STS_BAD_INDEX
   } status_type;

   typedef struct packed {
      logic signed [31:0] t;
      logic signed [31:0] v;
      logic               k;
   } bp_entry_type;

   localparam int ENTRY_W = $bits(bp_entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CUE,
      ST_LAST_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_EVAL,
      ST_MATH,
      ST_INS_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_DEL_END,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   typedef struct packed {
      logic        start;
      logic [32:0] mag;
      logic [31:0] st;
      logic [31:0] dt;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;
   } md_rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/beg_req_if.sv @@
// ----------------------------------------------------------------------------
// beg_req_if
// Request channel: one operation on the envelope per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface beg_req_if;
   import beg_pkg::*;

   logic               valid;
   logic               ready;
   op_type             op;
   logic signed [31:0] time_ticks;
   logic signed [31:0] point_value_in;
   logic               point_kind_in;
   logic [3:0]         point_index_in;
   logic               full_restart;

   modport source (
      output valid, op, time_ticks, point_value_in, point_kind_in,
             point_index_in, full_restart,
      input  ready
   );

   modport sink (
      input  valid, op, time_ticks, point_value_in, point_kind_in,
             point_index_in, full_restart,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/beg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// beg_rsp_if
// Response channel: one result per request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface beg_rsp_if;
   import beg_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   logic [3:0]         inserted_index;
   logic signed [31:0] level;
   logic               level_changed;
   logic signed [4:0]  active_segment;

   modport source (
      output valid, status, inserted_index, level, level_changed, active_segment,
      input  ready
   );

   modport sink (
      input  valid, status, inserted_index, level, level_changed, active_segment,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/beg_ram.sv @@
// ----------------------------------------------------------------------------
// beg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module beg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/beg_muldiv.sv @@
// ----------------------------------------------------------------------------
// beg_muldiv
// Shared iterative unit: shift-add multiply, then restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module beg_muldiv (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire beg_pkg::md_req_type md_req,
   output beg_pkg::md_rsp_type      md_rsp
);
   import beg_pkg::*;

   md_state_type        state_ff, state_in;
   logic [MD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]         mcand_ff, mcand_in;
   logic [31:0]         mplier_ff, mplier_in;
   logic [63:0]         acc_ff, acc_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         dt_ff, dt_in;
   logic                done_ff, done_in;
   logic [32:0]         trial;
   logic [32:0]         trial_diff;
   logic                qbit;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      dt_ff     <= dt_in;
   end

   // one quotient bit per cycle
   assign trial      = {rem_ff, acc_ff[63]};
   assign trial_diff = trial - {1'b0, dt_ff};
   assign qbit       = (trial >= {1'b0, dt_ff});

   // sequencing of the multiply and divide passes
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      dt_in     = dt_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               mcand_in  = {31'b0, md_req.mag};
               mplier_in = md_req.st;
               dt_in     = md_req.dt;
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = MD_MUL;
            end
         end
         MD_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[62:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[31:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == MD_CNT_W'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            rem_in = qbit ? trial_diff[31:0] : trial[31:0];
            acc_in = {acc_ff[62:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MD_CNT_W'(DIV_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.quo  = acc_ff;

endmodule

`default_nettype wire

@@ hw/rtl/breakpoint_envelope_generator_core.sv @@
// Steps: a cue reads the table point by point (last point first in restart mode) and runs
// the multiply and divide for a ramp. Insert moves entries up, delete moves them down,
// then a cue follows if needed. One transaction at a time: the table walk over the single
// RAM read port and the bit-serial multiply and divide keep the core busy with each one.
// Reset: synchronous, active high; table contents are kept, the count is cleared.
// ----------------------------------------------------------------------------
// breakpoint_envelope_generator_core
// Sorted breakpoint table with cue, insert, delete and restart operations.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_envelope_generator_core (
   input  wire logic clock,
   input  wire logic reset,
   beg_req_if.sink   req_ch,
   beg_rsp_if.source rsp_ch,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data
);
   import beg_pkg::*;

   seq_state_type      state_ff, state_in;
   op_type             op_ff, op_in;
   logic signed [31:0] tin_ff, tin_in;
   logic signed [31:0] val_ff, val_in;
   logic               kind_ff, kind_in;
   logic [3:0]         idx_ff, idx_in;
   logic               mode_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [31:0]        env_start_ff, env_start_in;
   logic [31:0]        last_cue_ff, last_cue_in;
   logic [31:0]        cue_t_ff, cue_t_in;
   logic signed [31:0] level_ff, level_in;
   logic signed [31:0] before_ff, before_in;
   logic signed [31:0] e_ff, e_in;
   logic signed [SEG_W-1:0] seg_ff, seg_in;
   logic signed [SEG_W-1:0] fseg_ff, fseg_in;
   bp_entry_type       cur_ff, cur_in;
   bp_entry_type       nxt_ff, nxt_in;
   status_type         status_ff, status_in;
   logic [IDX_W-1:0]   at_ff, at_in;
   logic               cueing_ff, cueing_in;
   logic               neg_ff, neg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [3:0]         rsp_ins_ff, rsp_ins_in;
   logic signed [31:0] rsp_level_ff, rsp_level_in;
   logic               rsp_changed_ff, rsp_changed_in;
   logic signed [4:0]  rsp_seg_ff, rsp_seg_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   bp_entry_type       rd_entry;

   md_req_type         md_req;
   md_rsp_type         md_rsp;

   logic [CNT_W-1:0]        count_m1;
   logic signed [SEG_W-1:0] count_s;
   logic signed [SEG_W-1:0] at_s;
   logic signed [SEG_W-1:0] idx_s;
   logic signed [32:0]      vdiff;
   logic signed [32:0]      tspan;
   logic signed [32:0]      tstep;
   logic signed [33:0]      v0_ext;
   logic signed [33:0]      q_ext;
   logic signed [33:0]      ramp_sum;
   logic                    load_rsp;

   // breakpoint table
   beg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = bp_entry_type'(ram_rd_data);

   // shared multiply / divide unit
   beg_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         env_start_ff <= '0;
         last_cue_ff  <= '0;
         level_ff     <= '0;
         seg_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         env_start_ff <= env_start_in;
         last_cue_ff  <= last_cue_in;
         level_ff     <= level_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      tin_ff         <= tin_in;
      val_ff         <= val_in;
      kind_ff        <= kind_in;
      idx_ff         <= idx_in;
      i_ff           <= i_in;
      cue_t_ff       <= cue_t_in;
      before_ff      <= before_in;
      e_ff           <= e_in;
      fseg_ff        <= fseg_in;
      cur_ff         <= cur_in;
      nxt_ff         <= nxt_in;
      status_ff      <= status_in;
      at_ff          <= at_in;
      cueing_ff      <= cueing_in;
      neg_ff         <= neg_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_ins_ff     <= rsp_ins_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_seg_ff     <= rsp_seg_in;
   end

   // index helpers
   assign count_m1 = count_ff - CNT_W'(1);
   assign count_s  = SEG_W'({1'b0, count_ff});
   assign at_s     = SEG_W'({1'b0, at_ff});
   assign idx_s    = SEG_W'({1'b0, idx_ff});

   // ramp operands from the two bracketing points
   assign vdiff  = 33'(nxt_ff.v) - 33'(cur_ff.v);
   assign tspan  = 33'(nxt_ff.t) - 33'(cur_ff.t);
   assign tstep  = 33'(e_ff) - 33'(cur_ff.t);
   assign v0_ext = 34'(cur_ff.v);
   assign q_ext  = $signed({1'b0, md_rsp.quo[32:0]});
   assign ramp_sum = neg_ff ? (v0_ext - q_ext) : (v0_ext + q_ext);

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tin_in       = tin_ff;
      val_in       = val_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      env_start_in = env_start_ff;
      last_cue_in  = last_cue_ff;
      cue_t_in     = cue_t_ff;
      level_in     = level_ff;
      before_in    = before_ff;
      e_in         = e_ff;
      seg_in       = seg_ff;
      fseg_in      = fseg_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      status_in    = status_ff;
      at_in        = at_ff;
      cueing_in    = cueing_ff;
      neg_in       = neg_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = i_ff[IDX_W-1:0];
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = i_ff[IDX_W-1:0];
      md_req.start = 1'b0;
      md_req.mag   = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
      md_req.st    = tstep[31:0];
      md_req.dt    = tspan[31:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.op;
               tin_in    = req_ch.time_ticks;
               val_in    = req_ch.point_value_in;
               kind_in   = req_ch.point_kind_in;
               idx_in    = req_ch.point_index_in;
               before_in = level_ff;
               status_in = STS_OK;
               at_in     = '0;
               unique case (req_ch.op)
                  OP_CUE: begin
                     cue_t_in = req_ch.time_ticks;
                     state_in = ST_CUE;
                  end
                  OP_INSERT: begin
                     if (count_ff >= CNT_W'(MAX_POINTS)) begin
                        status_in = STS_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        e_in      = req_ch.time_ticks;
                        i_in      = '0;
                        fseg_in   = '1;
                        cueing_in = 1'b0;
                        state_in  = ST_SCAN_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STS_BAD_INDEX;
                        state_in  = ST_DONE;
                     end else if (count_ff == CNT_W'(1)) begin
                        status_in = STS_LAST;
                        state_in  = ST_DONE;
                     end else if ({1'b0, req_ch.point_index_in} >= 5'(count_ff)) begin
                        status_in = STS_BAD_INDEX;
                        state_in  = ST_DONE;
                     end else begin
                        i_in     = CNT_W'(req_ch.point_index_in);
                        state_in = ST_SHIFT_RD;
                     end
                  end
                  OP_RESTART: begin
                     env_start_in = req_ch.full_restart ? '0 : last_cue_ff;
                     cue_t_in     = req_ch.full_restart ? '0 : last_cue_ff;
                     state_in     = ST_CUE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         // start a cue, fetch the last point for the restart check
         ST_CUE: begin
            last_cue_in = cue_t_ff;
            e_in        = cue_t_ff - env_start_ff;
            cueing_in   = 1'b1;
            i_in        = '0;
            fseg_in     = '1;
            ram_rd_addr = count_m1[IDX_W-1:0];
            if (mode_ff && (count_ff != '0)) begin
               state_in = ST_LAST_CHK;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_LAST_CHK: begin
            if (e_ff > rd_entry.t) begin
               env_start_in = last_cue_ff;
               e_in         = '0;
            end
            state_in = ST_SCAN_RD;
         end
         // walk the table for the last point at or before e
         ST_SCAN_RD: begin
            ram_rd_addr = i_ff[IDX_W-1:0];
            if (i_ff == count_ff) begin
               state_in = cueing_ff ? ST_EVAL : ST_INS_CHK;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (rd_entry.t > e_ff) begin
               nxt_in   = rd_entry;
               state_in = cueing_ff ? ST_EVAL : ST_INS_CHK;
            end else begin
               cur_in   = rd_entry;
               fseg_in  = SEG_W'({1'b0, i_ff});
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         // pick the level for the found segment
         ST_EVAL: begin
            seg_in   = fseg_ff;
            state_in = ST_DONE;
            if (count_ff == '0) begin
               level_in = '0;
            end else if (fseg_ff < 0) begin
               level_in = nxt_ff.v;
            end else if (fseg_ff >= count_s - SEG_W'(1)) begin
               level_in = cur_ff.v;
            end else if (cur_ff.k) begin
               level_in = cur_ff.v;
            end else begin
               md_req.start = 1'b1;
               neg_in       = vdiff[32];
               state_in     = ST_MATH;
            end
         end
         ST_MATH: begin
            if (md_rsp.done) begin
               level_in = ramp_sum[31:0];
               state_in = ST_DONE;
            end
         end
         // insert: reject a duplicate time, else open a slot
         ST_INS_CHK: begin
            if ((fseg_ff >= 0) && (cur_ff.t == e_ff)) begin
               status_in = STS_DUP;
               state_in  = ST_DONE;
            end else begin
               at_in    = IDX_W'(fseg_ff + SEG_W'(1));
               i_in     = count_ff;
               state_in = ST_SHIFT_RD;
            end
         end
         // move entries one at a time: read in ST_SHIFT_RD, then write in ST_SHIFT_WR
         ST_SHIFT_RD: begin
            if (op_ff == OP_INSERT) begin
               ram_rd_addr = IDX_W'(i_ff - CNT_W'(1));
               state_in    = (i_ff == CNT_W'(at_ff)) ? ST_PUT : ST_SHIFT_WR;
            end else begin
               ram_rd_addr = IDX_W'(i_ff + CNT_W'(1));
               state_in    = (i_ff == count_m1) ? ST_DEL_END : ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = i_ff[IDX_W-1:0];
            ram_wr_data = ram_rd_data;
            i_in        = (op_ff == OP_INSERT) ? (i_ff - CNT_W'(1)) : (i_ff + CNT_W'(1));
            state_in    = ST_SHIFT_RD;
         end
         ST_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = at_ff;
            ram_wr_data = {tin_ff, val_ff, kind_ff};
            count_in    = count_ff + CNT_W'(1);
            if (at_s <= seg_ff) begin
               cue_t_in = last_cue_ff;
               state_in = ST_CUE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DEL_END: begin
            count_in = count_m1;
            if (idx_s <= seg_ff) begin
               cue_t_in = last_cue_ff;
               state_in = ST_CUE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_ins_in     = rsp_ins_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_seg_in     = rsp_seg_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_ff;
         rsp_ins_in     = 4'(at_ff);
         rsp_level_in   = level_ff;
         rsp_changed_in = (level_ff != before_ff);
         rsp_seg_in     = 5'(seg_ff);
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.inserted_index = rsp_ins_ff;
   assign rsp_ch.level          = rsp_level_ff;
   assign rsp_ch.level_changed  = rsp_changed_ff;
   assign rsp_ch.active_segment = rsp_seg_ff;

endmodule

`default_nettype wire

@@ hw/rtl/beg_checker.sv @@
// ----------------------------------------------------------------------------
// beg_checker
// Port-level checks of the envelope core, bound into breakpoint_envelope_generator_core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module beg_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire beg_pkg::status_type rsp_status,
   input wire logic [3:0]         rsp_inserted_index,
   input wire logic signed [31:0] rsp_level,
   input wire logic               rsp_level_changed
);
   import beg_pkg::*;

   logic req_accept;
   logic rsp_stall;
   logic rsp_reject;
   logic reject_clean;

   assign req_accept   = req_valid && req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_reject   = rsp_valid && (rsp_status != STS_OK);
   assign reject_clean = (rsp_inserted_index == 4'd0) && !rsp_level_changed;

   // one transaction at a time: busy right after an accept
   `BEG_ASSERT(a_busy_after_accept, clock, reset, req_accept |=> !req_ready)

   // a stalled response keeps its level
   `BEG_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_level))

   // a rejected operation reports no insert position and leaves the level alone
   `BEG_ASSERT(a_reject_clean, clock, reset, rsp_reject |-> reject_clean)

   // no response straight out of reset
   `BEG_ASSERT_ALWAYS(a_reset_quiet, clock, !reset && $past(reset) |-> !rsp_valid)

endmodule

bind breakpoint_envelope_generator_core beg_checker u_beg_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_inserted_index (rsp_ch.inserted_index),
   .rsp_level          (rsp_ch.level),
   .rsp_level_changed  (rsp_ch.level_changed)
);

`default_nettype wire
